/* sv/hts_pkg.sv */
// shared types, codes and constants of the hrrn task scheduler
`default_nettype none

package hts_pkg;

    // defaults of the top-level parameters
    localparam int SlotsDef    = 7;
    localparam int TimeBitsDef = 16;
    localparam int IdBitsDef   = 8;

    // fixed field widths of the channel words
    localparam int ModeW = 2;
    localparam int IdW   = 8;
    localparam int TimeW = 16;
    localparam int StatW = 2;
    localparam int SlotW = 3;

    // step counter width and program addresses
    localparam int PcW = 4;
    localparam logic [PcW-1:0] PC_IDLE      = 4'd0;
    localparam logic [PcW-1:0] PC_CREATE    = 4'd1;
    localparam logic [PcW-1:0] PC_FIND      = 4'd2;
    localparam logic [PcW-1:0] PC_FIN       = 4'd3;
    localparam logic [PcW-1:0] PC_FIN_UPD   = 4'd4;
    localparam logic [PcW-1:0] PC_SCHED     = 4'd5;
    localparam logic [PcW-1:0] PC_SCHED_RD  = 4'd6;
    localparam logic [PcW-1:0] PC_SCHED_MUL = 4'd7;
    localparam logic [PcW-1:0] PC_SCHED_CMP = 4'd8;
    localparam logic [PcW-1:0] PC_SCHED_END = 4'd9;
    localparam logic [PcW-1:0] PC_EMIT      = 4'd10;
    localparam logic [PcW-1:0] PC_RUN       = 4'd11;
    localparam logic [PcW-1:0] PC_RUN_RES   = 4'd12;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_SCHED  = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_RUNNING  = 2'd1,
        SLOT_RUNNABLE = 2'd2
    } t_slot_st;

    typedef enum logic [StatW-1:0] {
        RES_OK   = 2'd0,
        RES_FULL = 2'd1,
        RES_IDLE = 2'd2,
        RES_ZERO = 2'd3
    } t_res;

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_CHK_SVC,
        UOP_FIND_FREE,
        UOP_FIN_RD,
        UOP_FIN_UPD,
        UOP_SCHED_INIT,
        UOP_SCHED_RD,
        UOP_SCHED_MUL,
        UOP_SCHED_CMP,
        UOP_SCHED_END,
        UOP_EMIT,
        UOP_RUN_RD,
        UOP_RUN_RES
    } t_uop;

    typedef struct packed {
        t_uop           op;
        logic [PcW-1:0] target;
    } t_cword;

    // datapath to sequencer: branch conditions
    typedef struct packed {
        logic  start;
        logic  hold;
        logic  take;
        t_mode mode;
    } t_cond;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [IdW-1:0]   task_id;
        logic [TimeW-1:0] arrival_time;
        logic [TimeW-1:0] service_time;
    } t_item;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [SlotW-1:0] slot;
        logic [IdW-1:0]   chosen_id;
        logic [TimeW-1:0] clock_now;
    } t_result;

endpackage

`default_nettype wire

/* sv/hts_if.sv */
// valid/ready channel interfaces for task items and result words
`default_nettype none

interface hts_item_if import hts_pkg::*;;
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hts_result_if import hts_pkg::*;;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/hrrn_task_scheduler_unit.sv */
// top level of the highest-response-ratio-next task scheduler
//
//  channel    dir  handshake     word
//  i_item     in   valid/ready   mode, task_id, arrival_time, service_time
//  o_result   out  valid/ready   status, slot, chosen_id, clock_now
//
//  one item at a time; a control store steps a single shared datapath
//  create: zero service time is refused, else a free-slot search, one slot a cycle
//  schedule: three steps per slot (read, multiply, compare); when nothing is
//  runnable the running slot is reported idle; finish advances the clock, frees the running slot, then schedules
//  synchronous active-low reset; slot 0 running, others free, clock zero
//  the result sits in an output register, so the next word is taken while it waits
`default_nettype none

module hrrn_task_scheduler_unit import hts_pkg::*; #(
    parameter int SLOTS     = SlotsDef,
    parameter int TIME_BITS = TimeBitsDef,
    parameter int ID_BITS   = IdBitsDef
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hts_item_if.sink      i_item,
    hts_result_if.source  o_result
);

    t_uop  op;
    t_cond cond;

    hts_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_op    (op)
    );

    hts_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .o_cond   (cond),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* sv/hts_ucode_rom.sv */
// control store: one control word per program step
`default_nettype none

module hts_ucode_rom import hts_pkg::*; (
    input  wire logic [PcW-1:0] i_pc,
    output t_cword              o_cword
);

    always_comb begin
        case (i_pc)
            PC_IDLE:      o_cword = '{op: UOP_IDLE,       target: PC_IDLE};
            PC_CREATE:    o_cword = '{op: UOP_CHK_SVC,    target: PC_EMIT};
            PC_FIND:      o_cword = '{op: UOP_FIND_FREE,  target: PC_EMIT};
            PC_FIN:       o_cword = '{op: UOP_FIN_RD,     target: PC_IDLE};
            PC_FIN_UPD:   o_cword = '{op: UOP_FIN_UPD,    target: PC_IDLE};
            PC_SCHED:     o_cword = '{op: UOP_SCHED_INIT, target: PC_IDLE};
            PC_SCHED_RD:  o_cword = '{op: UOP_SCHED_RD,   target: PC_SCHED_END};
            PC_SCHED_MUL: o_cword = '{op: UOP_SCHED_MUL,  target: PC_IDLE};
            PC_SCHED_CMP: o_cword = '{op: UOP_SCHED_CMP,  target: PC_SCHED_RD};
            PC_SCHED_END: o_cword = '{op: UOP_SCHED_END,  target: PC_RUN};
            PC_EMIT:      o_cword = '{op: UOP_EMIT,       target: PC_IDLE};
            PC_RUN:       o_cword = '{op: UOP_RUN_RD,     target: PC_IDLE};
            PC_RUN_RES:   o_cword = '{op: UOP_RUN_RES,    target: PC_EMIT};
            default:      o_cword = '{op: UOP_IDLE,       target: PC_IDLE};
        endcase
    end

endmodule

`default_nettype wire

/* sv/hts_sequencer.sv */
// step counter with dispatch on mode and conditional jumps
`default_nettype none

module hts_sequencer import hts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cond i_cond,
    output t_uop       o_op
);

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    logic [PcW-1:0] entry_pc;
    t_cword         cword;

    hts_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_cword (cword)
    );

    always_comb begin
        case (i_cond.mode)
            MODE_CREATE: entry_pc = PC_CREATE;
            MODE_SCHED:  entry_pc = PC_SCHED;
            MODE_FINISH: entry_pc = PC_FIN;
            default:     entry_pc = PC_RUN;
        endcase
    end

    always_comb begin
        if (i_cond.start) begin
            n_pc = entry_pc;
        end else if (i_cond.hold) begin
            n_pc = r_pc;
        end else if (i_cond.take) begin
            n_pc = cword.target;
        end else begin
            n_pc = r_pc + PcW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = cword.op;

endmodule

`default_nettype wire

/* sv/hts_datapath.sv */
// task table, clock, ratio compare and result register
`default_nettype none

module hts_datapath import hts_pkg::*; #(
    parameter int SLOTS     = SlotsDef,
    parameter int TIME_BITS = TimeBitsDef,
    parameter int ID_BITS   = IdBitsDef
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_uop     i_op,
    output t_cond         o_cond,
    hts_item_if.sink      i_item,
    hts_result_if.source  o_result
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TB = TIME_BITS;
    localparam int PW = 2 * TIME_BITS;

    // table payload memory
    logic [ID_BITS-1:0] mem_id  [SLOTS];
    logic [TB-1:0]      mem_arr [SLOTS];
    logic [TB-1:0]      mem_svc [SLOTS];

    t_slot_st           r_stat    [SLOTS];
    logic [SLOTS-1:0]   r_written;

    logic [ID_BITS-1:0] r_id;
    logic [TB-1:0]      r_arr;
    logic [TB-1:0]      r_svc;
    logic [TB-1:0]      r_clock;
    logic [AW-1:0]      r_run;
    logic [CW-1:0]      r_idx;

    logic [ID_BITS-1:0] r_rd_id;
    logic [TB-1:0]      r_rd_arr;
    logic [TB-1:0]      r_rd_svc;
    logic               r_rd_ok;

    logic               r_found;
    logic [AW-1:0]      r_best;
    logic [TB-1:0]      r_best_wait;
    logic [TB-1:0]      r_best_run;
    logic [ID_BITS-1:0] r_best_id;

    logic               r_cand;
    logic [TB-1:0]      r_w;
    logic [TB-1:0]      r_r;
    logic [ID_BITS-1:0] r_cid;
    logic [PW-1:0]      r_p_new;
    logic [PW-1:0]      r_p_best;

    t_res               r_res_status;
    logic [AW-1:0]      r_res_slot;
    logic [ID_BITS-1:0] r_res_id;

    t_result            r_out;
    logic               r_out_valid;

    logic [AW-1:0]      idx_a;
    logic [AW-1:0]      rd_addr;
    logic               accept;
    logic               idx_end;
    logic               svc_zero;
    logic               out_free;
    logic               emit_load;
    logic [ID_BITS-1:0] e_id;
    logic [TB-1:0]      e_arr;
    logic [TB-1:0]      e_svc;
    logic [TB-1:0]      w;
    logic [TB:0]        sum;
    logic               cand;
    logic               better;

    assign idx_a     = r_idx[AW-1:0];
    assign accept    = i_item.valid && i_item.ready;
    assign idx_end   = (r_idx == CW'(SLOTS));
    assign svc_zero  = (r_svc == '0);
    assign out_free  = !r_out_valid || o_result.ready;
    assign emit_load = (i_op == UOP_EMIT) && out_free;

    // a never-written entry reads as zero
    assign e_id  = r_rd_ok ? r_rd_id  : '0;
    assign e_arr = r_rd_ok ? r_rd_arr : '0;
    assign e_svc = r_rd_ok ? r_rd_svc : '0;

    assign rd_addr = (i_op == UOP_FIN_RD || i_op == UOP_RUN_RD) ? r_run : idx_a;

    assign cand   = (r_stat[idx_a] == SLOT_RUNNABLE) && (e_arr <= r_clock);
    assign w      = r_clock - e_arr;
    assign sum    = {1'b0, r_clock} + {1'b0, e_svc};
    assign better = r_cand && (!r_found || (r_p_new > r_p_best));

    always_comb begin
        o_cond.start = 1'b0;
        o_cond.hold  = 1'b0;
        o_cond.take  = 1'b0;
        o_cond.mode  = t_mode'(i_item.data.mode);
        case (i_op)
            UOP_IDLE: begin
                o_cond.start = accept;
                o_cond.hold  = !accept;
            end
            UOP_CHK_SVC:   o_cond.take = svc_zero;
            UOP_FIND_FREE: begin
                o_cond.take = idx_end || (r_stat[idx_a] == SLOT_FREE);
                o_cond.hold = !(idx_end || (r_stat[idx_a] == SLOT_FREE));
            end
            UOP_SCHED_RD:  o_cond.take = idx_end;
            UOP_SCHED_CMP: o_cond.take = 1'b1;
            UOP_SCHED_END: o_cond.take = !r_found;
            UOP_EMIT: begin
                o_cond.take = out_free;
                o_cond.hold = !out_free;
            end
            UOP_RUN_RES:   o_cond.take = 1'b1;
            default:       o_cond.take = 1'b0;
        endcase
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_op == UOP_FIND_FREE && !idx_end && r_stat[idx_a] == SLOT_FREE) begin
            mem_id[idx_a]  <= r_id;
            mem_arr[idx_a] <= r_arr;
            mem_svc[idx_a] <= r_svc;
        end
        r_rd_id  <= mem_id[rd_addr];
        r_rd_arr <= mem_arr[rd_addr];
        r_rd_svc <= mem_svc[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_stat[i] <= (i == 0) ? SLOT_RUNNING : SLOT_FREE;
            end
            r_written   <= '0;
            r_clock     <= '0;
            r_run       <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ok <= r_written[rd_addr];
            case (i_op)
                UOP_FIND_FREE: begin
                    if (!idx_end && r_stat[idx_a] == SLOT_FREE) begin
                        r_stat[idx_a]    <= SLOT_RUNNABLE;
                        r_written[idx_a] <= 1'b1;
                    end
                end
                UOP_FIN_UPD: begin
                    r_clock       <= sum[TB] ? '1 : sum[TB-1:0];
                    r_stat[r_run] <= SLOT_FREE;
                end
                UOP_SCHED_END: begin
                    if (r_found) begin
                        r_stat[r_best] <= SLOT_RUNNING;
                        r_run          <= r_best;
                    end
                end
                default: ;
            endcase
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            UOP_IDLE: begin
                if (accept) begin
                    r_id  <= ID_BITS'(32'(i_item.data.task_id));
                    r_arr <= TB'(32'(i_item.data.arrival_time));
                    r_svc <= TB'(32'(i_item.data.service_time));
                end
            end
            UOP_CHK_SVC: begin
                r_idx        <= '0;
                r_res_status <= RES_ZERO;
                r_res_slot   <= '0;
                r_res_id     <= '0;
            end
            UOP_FIND_FREE: begin
                if (idx_end) begin
                    r_res_status <= RES_FULL;
                    r_res_slot   <= '0;
                    r_res_id     <= '0;
                end else if (r_stat[idx_a] == SLOT_FREE) begin
                    r_res_status <= RES_OK;
                    r_res_slot   <= idx_a;
                    r_res_id     <= r_id;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            UOP_SCHED_INIT: begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_best      <= '0;
                r_best_wait <= '0;
                r_best_run  <= TB'(1);
                r_best_id   <= '0;
            end
            UOP_SCHED_MUL: begin
                // products registered, compared in the next step
                r_cand   <= cand;
                r_w      <= w;
                r_r      <= e_svc;
                r_cid    <= e_id;
                r_p_new  <= PW'(w) * PW'(r_best_run);
                r_p_best <= PW'(r_best_wait) * PW'(e_svc);
            end
            UOP_SCHED_CMP: begin
                if (better) begin
                    r_found     <= 1'b1;
                    r_best      <= idx_a;
                    r_best_wait <= r_w;
                    r_best_run  <= r_r;
                    r_best_id   <= r_cid;
                end
                r_idx <= r_idx + CW'(1);
            end
            UOP_SCHED_END: begin
                r_res_status <= RES_OK;
                r_res_slot   <= r_best;
                r_res_id     <= r_best_id;
            end
            UOP_RUN_RES: begin
                r_res_status <= RES_IDLE;
                r_res_slot   <= r_run;
                r_res_id     <= e_id;
            end
            default: ;
        endcase
        if (emit_load) begin
            r_out.status    <= r_res_status;
            r_out.slot      <= SlotW'(r_res_slot);
            r_out.chosen_id <= IdW'(r_res_id);
            r_out.clock_now <= TimeW'(r_clock);
        end
    end

    // no word is taken while reset is held
    assign i_item.ready   = i_rst_n && (i_op == UOP_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

`default_nettype wire
